[rtl/core/perspective_divide_viewport_top_macros.svh]
// assertion helpers shared by the checker file
`ifndef PERSPECTIVE_DIVIDE_VIEWPORT_TOP_MACROS_SVH
`define PERSPECTIVE_DIVIDE_VIEWPORT_TOP_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define PDV_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define PDV_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/core/pdv_pkg.sv]
// ----------------------------------------------------------------------------
// pdv_pkg
// shared constants and register codes of the perspective divide block
// ----------------------------------------------------------------------------
package pdv_pkg;

    localparam int COORD_W = 32;
    localparam int VP_W    = 16;
    localparam int DEPTH_W = 17;
    localparam int ADDR_W  = 5;
    localparam int DATA_W  = 32;

    typedef enum logic [2:0] {
        REG_VP_X       = 3'd0,
        REG_VP_Y       = 3'd1,
        REG_VP_W       = 3'd2,
        REG_VP_H       = 3'd3,
        REG_DEPTH_NEAR = 3'd4,
        REG_DEPTH_FAR  = 3'd5
    } reg_idx_t;

    typedef struct packed {
        logic [31:0] ax;
        logic [31:0] ay;
        logic [31:0] az;
        logic        sx;
        logic        sy;
        logic        sz;
    } coord_t;

    typedef struct packed {
        logic [31:0] inv;
        logic        flag;
    } tail_t;

endpackage

[rtl/core/perspective_divide_viewport_top.sv]
// ----------------------------------------------------------------------------
// perspective_divide_viewport_top
// clip-space vertex to window coordinates: reciprocal of w, ndc, viewport map
// ----------------------------------------------------------------------------
// usage
//   input channel: in_valid / in_stall with clip_x, clip_y, clip_z, clip_w
//   output channel: out_valid / out_stall with win_x, win_y, win_z, inv_w, fault
//   a transfer happens on a rising edge with valid high and stall low
//   throughput: one vertex per cycle while the receiver does not stall,
//   sustained, no dependence between vertices
//   stages: input, the restoring divider for 1/w that retires two quotient
//   bits per stage, then reciprocal, multiply, round, partial products, sum
//   and saturate stages
//   each stage holds a valid bit; a stalled receiver backs up the pipe one
//   stage at a time, empty stages keep filling, nothing is lost or repeated
//   reset clears the valid bits and loads the viewport defaults
//   (640 x 480 at origin 0, depth range 0 to 1.0); no clearing pass
//   registers are written through the apb-style port at byte address 4*index;
//   user rule, not enforced by the block: write only while the pipe is drained
// ----------------------------------------------------------------------------
module perspective_divide_viewport_top
    import pdv_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic                clk,
    input  logic                rst_n,
    // config port
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [DATA_W-1:0]   pwdata,
    output logic [DATA_W-1:0]   prdata,
    output logic                pready,
    // vertex in
    input  logic                in_valid,
    output logic                in_stall,
    input  logic signed [31:0]  clip_x,
    input  logic signed [31:0]  clip_y,
    input  logic signed [31:0]  clip_z,
    input  logic signed [31:0]  clip_w,
    // result out
    output logic                out_valid,
    input  logic                out_stall,
    output logic signed [31:0]  win_x,
    output logic signed [31:0]  win_y,
    output logic signed [31:0]  win_z,
    output logic signed [31:0]  inv_w,
    output logic                fault
);

    localparam int F    = FRAC_BITS;
    localparam int QB   = 2 * F + 2;          // quotient bits of 2^(2F+1) / |w|
    localparam int DSTG = QB / 2;             // two quotient bits per stage
    localparam int AVW  = 64 - F;             // ndc magnitude bits
    localparam int HW   = AVW - 32;           // upper slice of ndc magnitude
    localparam int DW   = (F + 1 > DEPTH_W) ? F + 1 : DEPTH_W;
    localparam int PW   = AVW + DW + 1;       // full scale product
    localparam int TW   = 45;                 // capped scale term, signed
    localparam int SW   = 48;                 // window sum before saturation

    localparam int ST_IN   = 0;
    localparam int ST_DIV0 = 1;
    localparam int ST_REC  = DSTG + 1;
    localparam int ST_MUL  = DSTG + 2;
    localparam int ST_RND  = DSTG + 3;
    localparam int ST_PP   = DSTG + 4;
    localparam int ST_SUM  = DSTG + 5;
    localparam int ST_OUT  = DSTG + 6;
    localparam int NST     = DSTG + 7;

    localparam logic [DW-1:0] FAR_RST  = DW'(1) << F;
    localparam logic [PW-1:0] TERM_CAP = PW'(1) << 43;
    localparam logic signed [SW-1:0] SMAX = SW'(32'sh7FFFFFFF);
    localparam logic signed [SW-1:0] SMIN = SW'(32'sh80000000);

    typedef struct packed {
        logic [31:0] val;
        logic        ovf;
    } sat_t;

    function automatic sat_t sat32(input logic signed [SW-1:0] v);
        sat_t r;
        if (v > SMAX)
        begin
            r.val = 32'h7FFFFFFF;
            r.ovf = 1'b1;
        end
        else if (v < SMIN)
        begin
            r.val = 32'h80000000;
            r.ovf = 1'b1;
        end
        else
        begin
            r.val = v[31:0];
            r.ovf = 1'b0;
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [VP_W-1:0] vp_x_reg;
    logic [VP_W-1:0] vp_y_reg;
    logic [VP_W-1:0] vp_w_reg;
    logic [VP_W-1:0] vp_h_reg;
    logic [DW-1:0]   dnear_reg;
    logic [DW-1:0]   dfar_reg;

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vp_x_reg  <= '0;
            vp_y_reg  <= '0;
            vp_w_reg  <= VP_W'(640);
            vp_h_reg  <= VP_W'(480);
            dnear_reg <= '0;
            dfar_reg  <= FAR_RST;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (paddr[4:2])
                REG_VP_X:       vp_x_reg  <= pwdata[15:0];
                REG_VP_Y:       vp_y_reg  <= pwdata[15:0];
                REG_VP_W:       vp_w_reg  <= pwdata[15:0];
                REG_VP_H:       vp_h_reg  <= pwdata[15:0];
                REG_DEPTH_NEAR: dnear_reg <= DW'(pwdata[16:0]);
                REG_DEPTH_FAR:  dfar_reg  <= DW'(pwdata[16:0]);
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[4:2])
            REG_VP_X:       prdata = DATA_W'(vp_x_reg);
            REG_VP_Y:       prdata = DATA_W'(vp_y_reg);
            REG_VP_W:       prdata = DATA_W'(vp_w_reg);
            REG_VP_H:       prdata = DATA_W'(vp_h_reg);
            REG_DEPTH_NEAR: prdata = DATA_W'(dnear_reg);
            REG_DEPTH_FAR:  prdata = DATA_W'(dfar_reg);
            default:        prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // stage handshake: a stage loads when it is empty or its successor loads
    // ------------------------------------------------------------------
    logic [NST-1:0] vld_reg;
    logic [NST:0]   rdy;

    assign rdy[NST] = !out_stall;
    for (genvar k = 0; k < NST; k++)
    begin : g_rdy
        assign rdy[k] = !vld_reg[k] || rdy[k+1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
        begin
            if (rdy[ST_IN])
                vld_reg[ST_IN] <= in_valid;
            for (int k = 1; k < NST; k++)
                if (rdy[k])
                    vld_reg[k] <= vld_reg[k-1];
        end
    end

    assign in_stall  = !rdy[ST_IN];
    assign out_valid = vld_reg[ST_OUT];

    // ------------------------------------------------------------------
    // input stage: magnitudes and signs
    // ------------------------------------------------------------------
    coord_t      in_co_reg;
    logic [31:0] in_aw_reg;
    logic        in_sw_reg;
    logic        in_zero_reg;

    always_ff @(posedge clk)
    begin
        if (rdy[ST_IN])
        begin
            in_co_reg.ax <= clip_x[31] ? 32'(-clip_x) : clip_x;
            in_co_reg.ay <= clip_y[31] ? 32'(-clip_y) : clip_y;
            in_co_reg.az <= clip_z[31] ? 32'(-clip_z) : clip_z;
            in_co_reg.sx <= clip_x[31];
            in_co_reg.sy <= clip_y[31];
            in_co_reg.sz <= clip_z[31];
            in_aw_reg    <= clip_w[31] ? 32'(-clip_w) : clip_w;
            in_sw_reg    <= clip_w[31];
            in_zero_reg  <= (clip_w == '0);
        end
    end

    // ------------------------------------------------------------------
    // restoring divider for 2^(2F+1) / |w|, two bits per stage
    // ------------------------------------------------------------------
    coord_t      dv_co_reg   [DSTG];
    logic [31:0] dv_rem_reg  [DSTG];
    logic [QB-1:0] dv_quo_reg [DSTG];
    logic [31:0] dv_aw_reg   [DSTG];
    logic        dv_sw_reg   [DSTG];
    logic        dv_zero_reg [DSTG];

    for (genvar j = 0; j < DSTG; j++)
    begin : g_div
        localparam logic FIRST = (j == 0);
        coord_t      co_in;
        logic [31:0] r_in;
        logic [QB-1:0] q_in;
        logic [31:0] aw_in;
        logic        sw_in;
        logic        z_in;
        logic [32:0] t0;
        logic [32:0] t1;
        logic [31:0] r_mid;
        logic [31:0] r_next;
        logic [QB-1:0] q_mid;
        logic [QB-1:0] q_next;

        if (j == 0)
        begin : g_head
            assign co_in = in_co_reg;
            assign r_in  = '0;
            assign q_in  = '0;
            assign aw_in = in_aw_reg;
            assign sw_in = in_sw_reg;
            assign z_in  = in_zero_reg;
        end
        else
        begin : g_chain
            assign co_in = dv_co_reg[j-1];
            assign r_in  = dv_rem_reg[j-1];
            assign q_in  = dv_quo_reg[j-1];
            assign aw_in = dv_aw_reg[j-1];
            assign sw_in = dv_sw_reg[j-1];
            assign z_in  = dv_zero_reg[j-1];
        end

        // the numerator has a single one, at its top bit
        always_comb
        begin
            t0 = {r_in, FIRST};
            if (t0 >= {1'b0, aw_in})
            begin
                r_mid = 32'(t0 - {1'b0, aw_in});
                q_mid = {q_in[QB-2:0], 1'b1};
            end
            else
            begin
                r_mid = t0[31:0];
                q_mid = {q_in[QB-2:0], 1'b0};
            end
            t1 = {r_mid, 1'b0};
            if (t1 >= {1'b0, aw_in})
            begin
                r_next = 32'(t1 - {1'b0, aw_in});
                q_next = {q_mid[QB-2:0], 1'b1};
            end
            else
            begin
                r_next = t1[31:0];
                q_next = {q_mid[QB-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk)
        begin
            if (rdy[ST_DIV0+j])
            begin
                dv_co_reg[j]   <= co_in;
                dv_rem_reg[j]  <= r_next;
                dv_quo_reg[j]  <= q_next;
                dv_aw_reg[j]   <= aw_in;
                dv_sw_reg[j]   <= sw_in;
                dv_zero_reg[j] <= z_in;
            end
        end
    end

    // ------------------------------------------------------------------
    // reciprocal: round, cap, sign, saturate
    // ------------------------------------------------------------------
    coord_t      rc_co_reg;
    tail_t       rc_tl_reg;
    logic [31:0] rc_mag_reg;
    logic        rc_neg_reg;

    logic [QB:0]   q_rnd;
    logic [63:0]   q64;
    logic [31:0]   inv_c;
    logic          neg_c;
    logic          flag_c;

    always_comb
    begin
        q_rnd = ({1'b0, dv_quo_reg[DSTG-1]} + (QB+1)'(1)) >> 1;
        q64   = 64'(q_rnd);
        if (q64 > (64'd1 << 32))
            q64 = 64'd1 << 32;
        neg_c  = 1'b0;
        flag_c = 1'b0;
        if (dv_zero_reg[DSTG-1])
        begin
            inv_c  = 32'h7FFFFFFF;
            flag_c = 1'b1;
        end
        else if (!dv_sw_reg[DSTG-1])
        begin
            if (q64 > 64'h7FFFFFFF)
            begin
                inv_c  = 32'h7FFFFFFF;
                flag_c = 1'b1;
            end
            else
                inv_c = q64[31:0];
        end
        else
        begin
            neg_c = 1'b1;
            if (q64 > 64'h80000000)
            begin
                inv_c  = 32'h80000000;
                flag_c = 1'b1;
            end
            else
                inv_c = 32'(64'd0 - q64);
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[ST_REC])
        begin
            rc_co_reg      <= dv_co_reg[DSTG-1];
            rc_tl_reg.inv  <= inv_c;
            rc_tl_reg.flag <= flag_c;
            rc_mag_reg     <= neg_c ? 32'(-inv_c) : inv_c;
            rc_neg_reg     <= neg_c;
        end
    end

    // ------------------------------------------------------------------
    // ndc products |c| * |1/w|
    // ------------------------------------------------------------------
    logic [63:0] mu_px_reg;
    logic [63:0] mu_py_reg;
    logic [63:0] mu_pz_reg;
    logic [2:0]  mu_neg_reg;
    tail_t       mu_tl_reg;

    always_ff @(posedge clk)
    begin
        if (rdy[ST_MUL])
        begin
            mu_px_reg  <= 64'(rc_co_reg.ax) * 64'(rc_mag_reg);
            mu_py_reg  <= 64'(rc_co_reg.ay) * 64'(rc_mag_reg);
            mu_pz_reg  <= 64'(rc_co_reg.az) * 64'(rc_mag_reg);
            mu_neg_reg <= {rc_co_reg.sz ^ rc_neg_reg,
                           rc_co_reg.sy ^ rc_neg_reg,
                           rc_co_reg.sx ^ rc_neg_reg};
            mu_tl_reg  <= rc_tl_reg;
        end
    end

    // ------------------------------------------------------------------
    // ndc rounding, ties away from zero on the magnitude
    // ------------------------------------------------------------------
    localparam logic [63:0] NDC_HALF = 64'd1 << (F - 1);

    logic [AVW-1:0] rn_mx_reg;
    logic [AVW-1:0] rn_my_reg;
    logic [AVW-1:0] rn_mz_reg;
    logic [2:0]     rn_neg_reg;
    tail_t          rn_tl_reg;

    logic [63:0] sx_sum;
    logic [63:0] sy_sum;
    logic [63:0] sz_sum;

    assign sx_sum = mu_px_reg + NDC_HALF;
    assign sy_sum = mu_py_reg + NDC_HALF;
    assign sz_sum = mu_pz_reg + NDC_HALF;

    always_ff @(posedge clk)
    begin
        if (rdy[ST_RND])
        begin
            rn_mx_reg  <= sx_sum[63:F];
            rn_my_reg  <= sy_sum[63:F];
            rn_mz_reg  <= sz_sum[63:F];
            rn_neg_reg <= mu_neg_reg;
            rn_tl_reg  <= mu_tl_reg;
        end
    end

    // ------------------------------------------------------------------
    // scale partial products, ndc split at bit 32
    // ------------------------------------------------------------------
    logic signed [DW+1:0] dz;
    logic [DW-1:0]        adz;
    logic                 dz_neg;
    logic [DW-1:0]        mw;
    logic [DW-1:0]        mh;

    always_comb
    begin
        dz     = $signed({2'b00, dfar_reg}) - $signed({2'b00, dnear_reg});
        dz_neg = dz[DW+1];
        adz    = dz_neg ? DW'(-dz) : dz[DW-1:0];
        mw     = DW'(vp_w_reg);
        mh     = DW'(vp_h_reg);
    end

    logic [32+DW-1:0] pp_xl_reg;
    logic [HW+DW-1:0] pp_xh_reg;
    logic [32+DW-1:0] pp_yl_reg;
    logic [HW+DW-1:0] pp_yh_reg;
    logic [32+DW-1:0] pp_zl_reg;
    logic [HW+DW-1:0] pp_zh_reg;
    logic [2:0]       pp_neg_reg;
    tail_t            pp_tl_reg;

    always_ff @(posedge clk)
    begin
        if (rdy[ST_PP])
        begin
            pp_xl_reg  <= (32+DW)'(rn_mx_reg[31:0]) * (32+DW)'(mw);
            pp_xh_reg  <= (HW+DW)'(rn_mx_reg[AVW-1:32]) * (HW+DW)'(mw);
            pp_yl_reg  <= (32+DW)'(rn_my_reg[31:0]) * (32+DW)'(mh);
            pp_yh_reg  <= (HW+DW)'(rn_my_reg[AVW-1:32]) * (HW+DW)'(mh);
            pp_zl_reg  <= (32+DW)'(rn_mz_reg[31:0]) * (32+DW)'(adz);
            pp_zh_reg  <= (HW+DW)'(rn_mz_reg[AVW-1:32]) * (HW+DW)'(adz);
            pp_neg_reg <= {rn_neg_reg[2] ^ dz_neg, rn_neg_reg[1:0]};
            pp_tl_reg  <= rn_tl_reg;
        end
    end

    // ------------------------------------------------------------------
    // partial product sum, rounding and cap at 2^43
    // ------------------------------------------------------------------
    logic [PW-1:0] px_full;
    logic [PW-1:0] py_full;
    logic [PW-1:0] pz_full;
    logic [PW-1:0] tx;
    logic [PW-1:0] ty;
    logic [PW-1:0] tz;

    always_comb
    begin
        px_full = (PW'(pp_xh_reg) << 32) + PW'(pp_xl_reg);
        py_full = (PW'(pp_yh_reg) << 32) + PW'(pp_yl_reg);
        pz_full = (PW'(pp_zh_reg) << 32) + PW'(pp_zl_reg);
        tx = (px_full + PW'(1)) >> 1;
        ty = (py_full + PW'(1)) >> 1;
        tz = (pz_full + (PW'(1) << F)) >> (F + 1);
        if (tx > TERM_CAP)
            tx = TERM_CAP;
        if (ty > TERM_CAP)
            ty = TERM_CAP;
        if (tz > TERM_CAP)
            tz = TERM_CAP;
    end

    logic signed [TW-1:0] sm_tx_reg;
    logic signed [TW-1:0] sm_ty_reg;
    logic signed [TW-1:0] sm_tz_reg;
    tail_t                sm_tl_reg;

    always_ff @(posedge clk)
    begin
        if (rdy[ST_SUM])
        begin
            sm_tx_reg <= pp_neg_reg[0] ? TW'(-tx[TW-1:0]) : tx[TW-1:0];
            sm_ty_reg <= pp_neg_reg[1] ? TW'(-ty[TW-1:0]) : ty[TW-1:0];
            sm_tz_reg <= pp_neg_reg[2] ? TW'(-tz[TW-1:0]) : tz[TW-1:0];
            sm_tl_reg <= pp_tl_reg;
        end
    end

    // ------------------------------------------------------------------
    // viewport offsets, saturation, output register
    // ------------------------------------------------------------------
    logic signed [SW-1:0] ox;
    logic signed [SW-1:0] oy;
    logic signed [SW-1:0] oz;
    logic signed [SW-1:0] wx_sum;
    logic signed [SW-1:0] wy_sum;
    logic signed [SW-1:0] wz_sum;
    logic [DW:0]          dsum;
    sat_t                 sat_x;
    sat_t                 sat_y;
    sat_t                 sat_z;

    always_comb
    begin
        ox     = (SW'(vp_x_reg) << F) + (SW'(vp_w_reg) << (F - 1));
        oy     = (SW'(vp_y_reg) << F) + (SW'(vp_h_reg) << (F - 1));
        dsum   = (DW+1)'(({1'b0, dfar_reg} + {1'b0, dnear_reg} + (DW+1)'(1)) >> 1);
        oz     = SW'(dsum);
        wx_sum = SW'(sm_tx_reg) + ox;
        wy_sum = SW'(sm_ty_reg) + oy;
        wz_sum = SW'(sm_tz_reg) + oz;
        sat_x  = sat32(wx_sum);
        sat_y  = sat32(wy_sum);
        sat_z  = sat32(wz_sum);
    end

    logic [31:0] win_x_reg;
    logic [31:0] win_y_reg;
    logic [31:0] win_z_reg;
    logic [31:0] inv_w_reg;
    logic        fault_reg;

    always_ff @(posedge clk)
    begin
        if (rdy[ST_OUT])
        begin
            win_x_reg <= sat_x.val;
            win_y_reg <= sat_y.val;
            win_z_reg <= sat_z.val;
            inv_w_reg <= sm_tl_reg.inv;
            fault_reg <= sm_tl_reg.flag | sat_x.ovf | sat_y.ovf | sat_z.ovf;
        end
    end

    assign win_x = win_x_reg;
    assign win_y = win_y_reg;
    assign win_z = win_z_reg;
    assign inv_w = inv_w_reg;
    assign fault = fault_reg;

endmodule

[rtl/core/pdv_checker.sv]
// ----------------------------------------------------------------------------
// pdv_checker
// port-level checks of the perspective divide block, bound to the top level
// ----------------------------------------------------------------------------
`include "perspective_divide_viewport_top_macros.svh"

module pdv_checker
    import pdv_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input logic [COORD_W-1:0] win_x,
    input logic               fault
);

    // a receiver that takes results leaves every stage free to move
    `PDV_ASSERT_NOW(a_open_out, !out_stall, !in_stall, "input stalled while output flows")

    // an empty output stage means the whole pipe can move
    `PDV_ASSERT_NOW(a_empty_out, !out_valid, !in_stall, "input stalled with empty output")

    // a stalled result stays put
    `PDV_ASSERT_NEXT(a_hold_out, out_valid && out_stall,
                     out_valid && $stable(win_x) && $stable(fault), "stalled result changed")

endmodule

bind perspective_divide_viewport_top pdv_checker u_pdv_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .win_x     (win_x),
    .fault     (fault)
);

[bench/tb.sv]
// ----------------------------------------------------------------------------
// tb
// checks the perspective divide and viewport block against a bit-exact
// predictor: directed corner vertices, then random vertices under several
// viewport and depth settings, with random idling and long receiver stalls
// ----------------------------------------------------------------------------
module tb;

    import pdv_pkg::*;

    localparam int FRAC     = 16;
    localparam int LATENCY  = FRAC + 7;
    localparam int WD_LIMIT = 4000;

    typedef struct packed {
        logic signed [31:0] cx;
        logic signed [31:0] cy;
        logic signed [31:0] cz;
        logic signed [31:0] cw;
    } vertex_t;

    typedef struct packed {
        logic signed [31:0] wx;
        logic signed [31:0] wy;
        logic signed [31:0] wz;
        logic signed [31:0] iw;
        logic               flt;
    } window_t;

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic pready;
    logic in_valid;
    logic in_stall;
    logic signed [31:0] clip_x;
    logic signed [31:0] clip_y;
    logic signed [31:0] clip_z;
    logic signed [31:0] clip_w;
    logic out_valid;
    logic out_stall;
    logic signed [31:0] win_x;
    logic signed [31:0] win_y;
    logic signed [31:0] win_z;
    logic signed [31:0] inv_w;
    logic fault;

    perspective_divide_viewport_top #(.FRAC_BITS(FRAC)) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .clip_x    (clip_x),
        .clip_y    (clip_y),
        .clip_z    (clip_z),
        .clip_w    (clip_w),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .win_x     (win_x),
        .win_y     (win_y),
        .win_z     (win_z),
        .inv_w     (inv_w),
        .fault     (fault)
    );

    // shadow copy of the viewport and depth registers
    logic [15:0] vp_x, vp_y, vp_wid, vp_hgt;
    logic [16:0] dep_near, dep_far;

    vertex_t pending_vertices[$];
    window_t expected_windows[$];

    int  error_count;
    int  vertices_sent;
    int  windows_checked;
    int  fault_count;
    int  idle_cycles;
    bit  tx_enable;      // sender allowed to offer transfers
    bit  rx_hold_req;    // request a long receiver hold-off
    bit  quiet_mode;     // no idling in the closing stretch
    int  tx_gap;
    int  rx_gap;
    int  rx_hold;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // magnitude of a 64 bit signed value
    function automatic logic [63:0] abs64(input logic signed [63:0] v);
        return v[63] ? -v : v;
    endfunction

    // round(v * m / 2^s) ties away from zero, magnitude capped at 2^cap
    function automatic logic signed [63:0] scale_round(input logic signed [63:0] v,
                                                      input logic signed [63:0] m,
                                                      input int s, input int cap);
        logic [63:0]  av, am, lim;
        logic [127:0] prod;
        logic [127:0] q;
        logic         neg;
        av   = abs64(v);
        am   = abs64(m);
        neg  = v[63] ^ m[63];
        lim  = 64'd1 << cap;
        prod = av * am;
        q    = (prod + (128'd1 << (s - 1))) >> s;
        if (q > {64'd0, lim})
            q = {64'd0, lim};
        return neg ? -$signed(q[63:0]) : $signed(q[63:0]);
    endfunction

    function automatic logic signed [63:0] clamp32(input logic signed [63:0] v,
                                                  inout logic flg);
        if (v > 64'sh7FFF_FFFF)
        begin
            flg = 1'b1;
            return 64'sh7FFF_FFFF;
        end
        if (v < -64'sh8000_0000)
        begin
            flg = 1'b1;
            return -64'sh8000_0000;
        end
        return v;
    endfunction

    // window coordinates for one clip-space vertex
    function automatic window_t project_vertex(input vertex_t vx);
        window_t r;
        logic flg;
        logic signed [63:0] inv, nx, ny, nz, wx, wy, wz, dz, oz;
        logic [63:0] aw, q;
        flg = 1'b0;
        dz  = $signed({47'd0, dep_far}) - $signed({47'd0, dep_near});
        oz  = ({47'd0, dep_far} + {47'd0, dep_near} + 64'd1) >> 1;
        if (vx.cw == 0)
        begin
            flg = 1'b1;
            inv = 64'sh7FFF_FFFF;
        end
        else
        begin
            aw = abs64(64'(vx.cw));
            q  = (((64'd1 << (2 * FRAC + 1)) / aw) + 64'd1) >> 1;
            if (q > (64'd1 << 32))
                q = 64'd1 << 32;
            inv = vx.cw < 0 ? -$signed(q) : $signed(q);
            inv = clamp32(inv, flg);
        end
        nx = scale_round(64'(vx.cx), inv, FRAC, 61);
        ny = scale_round(64'(vx.cy), inv, FRAC, 61);
        nz = scale_round(64'(vx.cz), inv, FRAC, 61);
        wx = scale_round(nx, $signed({48'd0, vp_wid}), 1, 43)
           + $signed({48'd0, vp_x} << FRAC) + $signed({48'd0, vp_wid} << (FRAC - 1));
        wy = scale_round(ny, $signed({48'd0, vp_hgt}), 1, 43)
           + $signed({48'd0, vp_y} << FRAC) + $signed({48'd0, vp_hgt} << (FRAC - 1));
        wz = scale_round(nz, dz, FRAC + 1, 43) + oz;
        r.wx  = 32'(clamp32(wx, flg));
        r.wy  = 32'(clamp32(wy, flg));
        r.wz  = 32'(clamp32(wz, flg));
        r.iw  = inv[31:0];
        r.flt = flg;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // driver: offers vertices from the pending queue, random idle bursts
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            clip_x   <= '0;
            clip_y   <= '0;
            clip_z   <= '0;
            clip_w   <= '0;
            tx_gap   = 0;
        end
        else
        begin
            // a transfer just completed: predict it and drop it from the queue
            if (in_valid && !in_stall)
            begin
                expected_windows.push_back(project_vertex(pending_vertices.pop_front()));
                vertices_sent++;
            end
            if (in_valid && in_stall)
            begin
                // payload held while stalled
            end
            else if (tx_gap > 0)
            begin
                tx_gap--;
                in_valid <= 1'b0;
            end
            else if (tx_enable && pending_vertices.size() > 0)
            begin
                if (!quiet_mode && $urandom_range(0, 5) == 0)
                begin
                    tx_gap   = $urandom_range(0, 2);
                    in_valid <= 1'b0;
                end
                else
                begin
                    in_valid <= 1'b1;
                    clip_x   <= pending_vertices[0].cx;
                    clip_y   <= pending_vertices[0].cy;
                    clip_z   <= pending_vertices[0].cz;
                    clip_w   <= pending_vertices[0].cw;
                end
            end
            else
                in_valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------------
    // monitor: random stall bursts, long hold-off on request, result checks
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        window_t exp_w;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            rx_gap    = 0;
            rx_hold   = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_windows.size() == 0)
                begin
                    $error("result transfer with nothing expected");
                    error_count++;
                end
                else
                begin
                    exp_w = expected_windows.pop_front();
                    if (win_x !== exp_w.wx)
                    begin
                        $error("win_x expected %h actual %h", exp_w.wx, win_x);
                        error_count++;
                    end
                    if (win_y !== exp_w.wy)
                    begin
                        $error("win_y expected %h actual %h", exp_w.wy, win_y);
                        error_count++;
                    end
                    if (win_z !== exp_w.wz)
                    begin
                        $error("win_z expected %h actual %h", exp_w.wz, win_z);
                        error_count++;
                    end
                    if (inv_w !== exp_w.iw)
                    begin
                        $error("inv_w expected %h actual %h", exp_w.iw, inv_w);
                        error_count++;
                    end
                    if (fault !== exp_w.flt)
                    begin
                        $error("fault expected %b actual %b", exp_w.flt, fault);
                        error_count++;
                    end
                    windows_checked++;
                    if (exp_w.flt)
                        fault_count++;
                end
            end
            // stall pattern for the next cycle
            if (rx_hold_req && rx_hold == 0)
            begin
                rx_hold     = 80;
                rx_hold_req = 1'b0;
            end
            if (rx_hold > 0)
            begin
                rx_hold--;
                out_stall <= 1'b1;
            end
            else if (rx_gap > 0)
            begin
                rx_gap--;
                out_stall <= 1'b1;
            end
            else if (!quiet_mode && $urandom_range(0, 5) == 0)
            begin
                rx_gap    = $urandom_range(0, 2);
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // watchdog: cycles with no transfer on either channel
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WD_LIMIT)
            begin
                $display("FAIL perspective_divide_viewport_top");
                $finish;
            end
        end
    end

    // apb write, setup then access, and shadow update
    task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(idx) << 2;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_VP_X:       vp_x     = value[15:0];
            REG_VP_Y:       vp_y     = value[15:0];
            REG_VP_W:       vp_wid   = value[15:0];
            REG_VP_H:       vp_hgt   = value[15:0];
            REG_DEPTH_NEAR: dep_near = value[16:0];
            REG_DEPTH_FAR:  dep_far  = value[16:0];
            default: ;
        endcase
    endtask

    task automatic set_viewport(input logic [15:0] x0, input logic [15:0] y0,
                                input logic [15:0] wd, input logic [15:0] ht,
                                input logic [16:0] dn, input logic [16:0] df);
        write_reg(REG_VP_X, 32'(x0));
        write_reg(REG_VP_Y, 32'(y0));
        write_reg(REG_VP_W, 32'(wd));
        write_reg(REG_VP_H, 32'(ht));
        write_reg(REG_DEPTH_NEAR, 32'(dn));
        write_reg(REG_DEPTH_FAR, 32'(df));
    endtask

    // let every queued vertex go through and every result come back
    task automatic drain;
        while (pending_vertices.size() > 0 || expected_windows.size() > 0 || in_valid)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    function automatic logic [31:0] rand_coord;
        case ($urandom_range(0, 4))
            0:       return $urandom;
            1:       return 32'($signed($urandom_range(0, 262144)) - 131072);
            2:       return 32'($signed($urandom_range(0, 2097152)) - 1048576);
            3:       return {{8{$urandom_range(0, 1) == 1}}, 24'($urandom)};
            default: return 32'($signed($urandom_range(0, 65536)) - 32768);
        endcase
    endfunction

    function automatic logic [31:0] rand_w;
        case ($urandom_range(0, 7))
            0:       return 32'($signed($urandom_range(0, 8)) - 4);   // tiny, incl. zero
            1:       return $urandom;
            2:       return 32'($signed($urandom_range(0, 600000)) - 300000);
            default: return 32'($urandom_range(32768, 2000000));
        endcase
    endfunction

    task automatic queue_random(input int n);
        vertex_t v;
        for (int k = 0; k < n; k++)
        begin
            v.cw = rand_w();
            // mostly vertices inside the clip volume, some arbitrary ones
            if ($urandom_range(0, 3) != 0 && v.cw > 0)
            begin
                v.cx = 32'($signed(64'($urandom) % (64'(v.cw) + 1)) * ($urandom_range(0, 1) ? 1 : -1));
                v.cy = 32'($signed(64'($urandom) % (64'(v.cw) + 1)) * ($urandom_range(0, 1) ? 1 : -1));
                v.cz = 32'($signed(64'($urandom) % (64'(v.cw) + 1)) * ($urandom_range(0, 1) ? 1 : -1));
            end
            else
            begin
                v.cx = rand_coord();
                v.cy = rand_coord();
                v.cz = rand_coord();
            end
            pending_vertices.push_back(v);
        end
    endtask

    task automatic queue_vertex(input logic [31:0] x, input logic [31:0] y,
                                input logic [31:0] z, input logic [31:0] w);
        vertex_t v;
        v.cx = x;
        v.cy = y;
        v.cz = z;
        v.cw = w;
        pending_vertices.push_back(v);
    endtask

    initial
    begin
        error_count     = 0;
        vertices_sent   = 0;
        windows_checked = 0;
        fault_count     = 0;
        idle_cycles     = 0;
        tx_enable       = 1'b0;
        rx_hold_req     = 1'b0;
        quiet_mode      = 1'b0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        // reset defaults of the shadow registers
        vp_x = 16'd0;
        vp_y = 16'd0;
        vp_wid = 16'd640;
        vp_hgt = 16'd480;
        dep_near = 17'd0;
        dep_far = 17'h10000;
        rst_n = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed corners under reset defaults
        queue_vertex(32'h0, 32'h0, 32'h0, 32'h0001_0000);        // center
        queue_vertex(32'h0001_0000, 32'hFFFF_0000, 32'h0001_0000, 32'h0001_0000);
        queue_vertex(32'h0, 32'h0, 32'h0, 32'h0);                // zero w
        queue_vertex(32'h0001_0000, 32'h0, 32'hFFFF_0000, 32'h0);
        queue_vertex(32'h0001_0000, 32'h0001_0000, 32'h0, 32'h1); // reciprocal overflow
        queue_vertex(32'h0, 32'h0, 32'h0, 32'hFFFF_FFFF);
        queue_vertex(32'h0, 32'h0, 32'h0, 32'h2);                // exactly 2^31
        queue_vertex(32'h0, 32'h0, 32'h0, 32'hFFFF_FFFE);        // exactly -2^31
        queue_vertex(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        queue_vertex(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
        queue_vertex(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0001_0000);
        queue_vertex(32'h0000_8000, 32'hFFFF_8000, 32'h0000_8000, 32'h0003_0000);
        queue_vertex(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_vertex(32'h5555_5555, 32'hAAAA_AAAA, 32'h1234_5678, 32'h0000_0003);
        queue_vertex(32'hAAAA_AAAA, 32'h5555_5555, 32'hEDCB_A987, 32'hFFFC_0000);
        tx_enable = 1'b1;
        drain();

        // maximal viewport and inverted depth range
        set_viewport(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 17'h10000, 17'h0);
        queue_vertex(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
        queue_vertex(32'hFFFF_0000, 32'hFFFF_0000, 32'hFFFF_0000, 32'h0001_0000);
        queue_vertex(32'h0, 32'h0, 32'h0, 32'h0);
        queue_random(100);
        drain();

        // degenerate viewport, long receiver hold-off while the pipe fills
        set_viewport(16'h0, 16'h0, 16'h0, 16'h0, 17'h0, 17'h0);
        rx_hold_req = 1'b1;
        queue_random(100);
        drain();

        // sender waits until all results are back before this phase
        set_viewport(16'd100, 16'd50, 16'd1920, 16'd1080, 17'h04000, 17'h0C000);
        queue_random(120);
        drain();

        // depth extremes, last stretch with no idling
        set_viewport(16'd7, 16'd3, 16'd1, 16'd2, 17'h1FFFF, 17'h10000);
        quiet_mode = 1'b1;
        queue_random(120);
        drain();

        $display("covered %0d vertices, %0d results checked, %0d with fault set",
                 vertices_sent, windows_checked, fault_count);
        $display("five register settings including full-range viewport and depth extremes");
        if (error_count == 0 && expected_windows.size() == 0)
            $display("PASS perspective_divide_viewport_top");
        else
            $display("FAIL perspective_divide_viewport_top");
        $finish;
    end

endmodule
